@@ sv/tlfs_pkg.sv @@
// types and constants shared by the feedback scheduler
// no dependencies
package tlfs_pkg;
  localparam int unsigned ID_W = 3;
  localparam int unsigned NUM_IDS = 8;

  typedef enum logic [1:0] {
    CMD_ADMIT    = 2'd0,
    CMD_DISPATCH = 2'd1,
    CMD_EXPIRE   = 2'd2,
    CMD_FINISH   = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_BUSY   = 3'd3,
    ST_NO_JOB = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    LV_HIGH = 2'd0,
    LV_MED  = 2'd1,
    LV_LOW  = 2'd2
  } level_t;

  localparam logic [0:0] REG_HIGH_LIMIT = 1'd0;
  localparam logic [0:0] REG_MED_LIMIT  = 1'd1;

  typedef struct packed {
    logic [1:0]      command;
    logic [ID_W-1:0] job_id;
  } cmd_beat_t;

  typedef struct packed {
    logic [2:0]      status;
    logic [ID_W-1:0] result_job;
    logic [1:0]      level;
    logic [1:0]      next_level;
  } res_beat_t;
endpackage

@@ sv/tlfs_if.sv @@
// valid/ready channel interfaces for commands and results
// depends on tlfs_pkg
interface tlfs_cmd_if;
  logic valid;
  logic ready;
  logic [1:0] command;
  logic [tlfs_pkg::ID_W-1:0] job_id;
  modport source (output valid, command, job_id, input ready);
  modport sink (input valid, command, job_id, output ready);
endinterface

interface tlfs_res_if;
  logic valid;
  logic ready;
  logic [2:0] status;
  logic [tlfs_pkg::ID_W-1:0] result_job;
  logic [1:0] level;
  logic [1:0] next_level;
  modport source (output valid, status, result_job, level, next_level, input ready);
  modport sink (input valid, status, result_job, level, next_level, output ready);
endinterface

@@ sv/tlfs_front.sv @@
// front end: takes command beats and queues them
// depends on tlfs_pkg
module tlfs_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            in_command,
  input  logic [tlfs_pkg::ID_W-1:0] in_job_id,
  output logic                  q_valid,
  input  logic                  q_ready,
  output tlfs_pkg::cmd_beat_t   q_beat
);
  // two-entry queue
  tlfs_pkg::cmd_beat_t slot [2];
  logic rd, wr;
  logic [1:0] count;
  logic push, pop;

  assign in_ready = (count != 2'd2);
  assign push = in_valid && in_ready;
  assign pop = q_valid && q_ready;
  assign q_valid = (count != 2'd0);
  assign q_beat = slot[rd];

  always_ff @(posedge clk) begin
    if (rst) begin
      rd <= 1'b0;
      wr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) wr <= ~wr;
      if (pop) rd <= ~rd;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr].command <= in_command;
      slot[wr].job_id <= in_job_id;
    end
  end
endmodule

@@ sv/tlfs_back.sv @@
// back end: queues, per-job counts and the command executor with result register
// depends on tlfs_pkg
module tlfs_back #(
  parameter int unsigned MAX_JOBS = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                q_valid,
  output logic                q_ready,
  input  tlfs_pkg::cmd_beat_t q_beat,
  input  logic [3:0]          high_limit,
  input  logic [3:0]          medium_limit,
  output logic                r_valid,
  input  logic                r_ready,
  output tlfs_pkg::res_beat_t r_beat
);
  localparam int unsigned PW = (MAX_JOBS > 1) ? $clog2(MAX_JOBS) : 1;
  localparam int unsigned FW = $clog2(MAX_JOBS + 1);
  localparam int unsigned IW = tlfs_pkg::ID_W;

  logic [IW-1:0] qmem [3][MAX_JOBS];
  logic [PW-1:0] head [3];
  logic [FW-1:0] fill [3];
  logic [3:0] hruns [tlfs_pkg::NUM_IDS];
  logic [3:0] mruns [tlfs_pkg::NUM_IDS];
  logic [1:0] jlev [tlfs_pkg::NUM_IDS];
  logic [IW-1:0] running_job;
  logic running_valid;

  logic go;
  tlfs_pkg::res_beat_t res;
  logic do_push, do_pop, set_run, clr_run;
  logic [1:0] pq, popq, nx;
  logic [IW-1:0] push_id, got;
  logic [PW-1:0] tail [3];

  assign q_ready = !r_valid || r_ready;
  assign go = q_valid && q_ready;

  function automatic logic [PW-1:0] wrap(input logic [PW:0] v);
    logic [PW:0] m;
    m = v - (PW+1)'(MAX_JOBS);
    return (v >= (PW+1)'(MAX_JOBS)) ? m[PW-1:0] : v[PW-1:0];
  endfunction

  always_comb begin
    for (int q = 0; q < 3; q++)
      tail[q] = wrap({1'b0, head[q]} + (PW+1)'(fill[q]));
  end

  always_comb begin
    logic [IW-1:0] j;
    j = running_job;
    res = '0;
    do_push = 1'b0;
    do_pop = 1'b0;
    set_run = 1'b0;
    clr_run = 1'b0;
    pq = tlfs_pkg::LV_HIGH;
    popq = tlfs_pkg::LV_HIGH;
    push_id = q_beat.job_id;
    got = '0;
    nx = tlfs_pkg::LV_HIGH;
    case (q_beat.command)
      tlfs_pkg::CMD_ADMIT: begin
        res.result_job = q_beat.job_id;
        if (fill[0] == FW'(MAX_JOBS)) res.status = tlfs_pkg::ST_FULL;
        else begin
          res.status = tlfs_pkg::ST_OK;
          do_push = 1'b1;
        end
      end
      tlfs_pkg::CMD_DISPATCH: begin
        if (running_valid) begin
          res.status = tlfs_pkg::ST_BUSY;
          res.result_job = j;
          res.level = jlev[j];
          res.next_level = jlev[j];
        end else if (fill[0] != '0 || fill[1] != '0 || fill[2] != '0) begin
          if (fill[0] != '0) popq = tlfs_pkg::LV_HIGH;
          else if (fill[1] != '0) popq = tlfs_pkg::LV_MED;
          else popq = tlfs_pkg::LV_LOW;
          got = qmem[popq][head[popq]];
          do_pop = 1'b1;
          set_run = 1'b1;
          res.status = tlfs_pkg::ST_OK;
          res.result_job = got;
          res.level = popq;
          res.next_level = popq;
        end else res.status = tlfs_pkg::ST_EMPTY;
      end
      default: begin
        if (!running_valid) res.status = tlfs_pkg::ST_NO_JOB;
        else if (q_beat.command == tlfs_pkg::CMD_FINISH) begin
          clr_run = 1'b1;
          res.status = tlfs_pkg::ST_OK;
          res.result_job = j;
          res.level = jlev[j];
          res.next_level = jlev[j];
        end else begin
          if (hruns[j] < high_limit) nx = tlfs_pkg::LV_HIGH;
          else if (mruns[j] < medium_limit) nx = tlfs_pkg::LV_MED;
          else nx = tlfs_pkg::LV_LOW;
          res.result_job = j;
          res.level = jlev[j];
          if (fill[nx] == FW'(MAX_JOBS)) begin
            res.status = tlfs_pkg::ST_FULL;
            res.next_level = jlev[j];
          end else begin
            res.status = tlfs_pkg::ST_OK;
            res.next_level = nx;
            do_push = 1'b1;
            pq = nx;
            push_id = j;
            clr_run = 1'b1;
          end
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r_valid <= 1'b0;
      running_valid <= 1'b0;
      running_job <= '0;
      for (int q = 0; q < 3; q++) begin
        head[q] <= '0;
        fill[q] <= '0;
      end
    end else begin
      if (go) r_valid <= 1'b1;
      else if (r_ready) r_valid <= 1'b0;
      if (go) begin
        if (do_push) fill[pq] <= fill[pq] + FW'(1);
        if (do_pop) begin
          fill[popq] <= fill[popq] - FW'(1);
          head[popq] <= wrap({1'b0, head[popq]} + (PW+1)'(1));
        end
        if (set_run) begin
          running_valid <= 1'b1;
          running_job <= got;
        end
        if (clr_run) running_valid <= 1'b0;
      end
    end
  end

  // payload: queue storage, per-job counts, result register
  always_ff @(posedge clk) begin
    if (go) begin
      r_beat <= res;
      if (do_push) qmem[pq][tail[pq]] <= push_id;
      if (do_push && q_beat.command == tlfs_pkg::CMD_ADMIT) begin
        hruns[q_beat.job_id] <= 4'd1;
        mruns[q_beat.job_id] <= 4'd0;
        jlev[q_beat.job_id] <= tlfs_pkg::LV_HIGH;
      end
      if (do_pop) jlev[got] <= popq;
      if (do_push && q_beat.command == tlfs_pkg::CMD_EXPIRE) begin
        jlev[running_job] <= nx;
        if (nx == tlfs_pkg::LV_HIGH) hruns[running_job] <= hruns[running_job] + 4'd1;
        else if (nx == tlfs_pkg::LV_MED) mruns[running_job] <= mruns[running_job] + 4'd1;
      end
    end
  end
endmodule

@@ sv/three_level_feedback_scheduler.sv @@
// top level of the three-level feedback scheduler
// depends on tlfs_pkg, tlfs_if, tlfs_front and tlfs_back
//
// usage
//   cmd channel (sink): one beat per command, fields command and job_id
//   res channel (source): exactly one result beat per command
//   apb port: register 0 high_limit at 0x0, register 1 medium_limit at 0x4
//   path: a command is written into a front queue slot, then executed
//     from that slot into the result register, from which its result
//     beat is taken
//   throughput: one command per cycle while the result receiver keeps up,
//     set by the single executor that reads and updates queue state in one step
//   a two-entry queue parts front and back; the result register lets the
//     next command run while the last result is still being taken
//   when the receiver stalls the executor holds, the front queue fills and
//     cmd ready drops once it holds two beats
//   reset (synchronous, active high) empties all queues, clears the
//     running job and loads the limits 2 and 4; queue contents and per-job
//     counts stay undefined until written
module three_level_feedback_scheduler #(
  parameter int unsigned MAX_JOBS = 8
) (
  input  logic        clk,
  input  logic        rst,
  tlfs_cmd_if.sink    cmd,
  tlfs_res_if.source  res,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  logic [3:0] high_limit, medium_limit;
  logic q_valid, q_ready;
  tlfs_pkg::cmd_beat_t q_beat;
  tlfs_pkg::res_beat_t r_beat;

  // configuration registers
  assign pready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      high_limit <= 4'd2;
      medium_limit <= 4'd4;
    end else if (psel && penable && pwrite && pready && paddr[1:0] == 2'b00) begin
      if (paddr[2] == tlfs_pkg::REG_HIGH_LIMIT) high_limit <= pwdata[3:0];
      else medium_limit <= pwdata[3:0];
    end
  end
  assign prdata = (paddr[2] == tlfs_pkg::REG_HIGH_LIMIT) ? {28'd0, high_limit}
                                                       : {28'd0, medium_limit};

  // front: accept and buffer command beats
  tlfs_front u_front (
    .clk(clk), .rst(rst),
    .in_valid(cmd.valid), .in_ready(cmd.ready),
    .in_command(cmd.command), .in_job_id(cmd.job_id),
    .q_valid(q_valid), .q_ready(q_ready), .q_beat(q_beat)
  );

  // back: execute against queue state
  tlfs_back #(.MAX_JOBS(MAX_JOBS)) u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_ready(q_ready), .q_beat(q_beat),
    .high_limit(high_limit), .medium_limit(medium_limit),
    .r_valid(res.valid), .r_ready(res.ready), .r_beat(r_beat)
  );

  assign res.status = r_beat.status;
  assign res.result_job = r_beat.result_job;
  assign res.level = r_beat.level;
  assign res.next_level = r_beat.next_level;
endmodule
